// ----- hw/rtl/pda_pkg.sv -----
// ----------------------------------------------------------------------------
// pda_pkg: shared types and constants of the parking distance alarm
// Field widths, register codes and reset values, word structs and the
// reciprocal constants for the echo width to centimetre conversion.
// ----------------------------------------------------------------------------
package pda_pkg;

  // field widths
  localparam int unsigned CaptureW = 16;
  localparam int unsigned DistW    = 10;
  localparam int unsigned LimitW   = 10;
  localparam int unsigned PeriodW  = 8;
  localparam int unsigned VolumeW  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // echo width / 116 = (width >> 2) / 29, done as (x * 18079) >> 19
  localparam int unsigned EchoPreShift = 2;
  localparam int unsigned QuotInW      = CaptureW - EchoPreShift;
  localparam int unsigned RecipMul     = 18079;
  localparam int unsigned RecipShift   = 19;
  localparam int unsigned ProdW        = QuotInW + 15;

  // register reset values
  localparam logic [PeriodW-1:0] TriggerPeriodRst = 8'd50;
  localparam logic [LimitW-1:0]  NearLimitRst     = 10'd10;
  localparam logic [LimitW-1:0]  WarnLimitRst     = 10'd20;
  localparam logic [LimitW-1:0]  FarIntervalRst   = 10'd600;
  localparam logic [LimitW-1:0]  MidIntervalRst   = 10'd250;
  localparam logic [LimitW-1:0]  NearIntervalRst  = 10'd100;
  localparam logic [VolumeW-1:0] ToneVolumeRst    = 8'd80;

  // register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_TRIGGER_PERIOD = 3'd0,
    REG_NEAR_LIMIT     = 3'd1,
    REG_WARN_LIMIT     = 3'd2,
    REG_FAR_INTERVAL   = 3'd3,
    REG_MID_INTERVAL   = 3'd4,
    REG_NEAR_INTERVAL  = 3'd5,
    REG_TONE_VOLUME    = 3'd6
  } cfg_reg_e;

  // item mode codes
  localparam logic ModeTick = 1'b0;
  localparam logic ModeEcho = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [CaptureW-1:0] capture_time;
    logic                button_cw_n;
    logic                button_ccw_n;
  } item_t;

  typedef struct packed {
    logic               trigger_pulse;
    logic               lamp_ready;
    logic               lamp_warn;
    logic               lamp_danger;
    logic               drive_cw;
    logic               drive_ccw;
    logic [VolumeW-1:0] buzzer_level;
    logic [DistW-1:0]   distance_now;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [RegIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

// ----- hw/rtl/pda_if.sv -----
// ----------------------------------------------------------------------------
// pda_if: valid/ready channels of the parking distance alarm
// Input item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface pda_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [pda_pkg::CaptureW-1:0]  capture_time;
  logic                          button_cw_n;
  logic                          button_ccw_n;

  modport source (output valid, mode, capture_time, button_cw_n, button_ccw_n,
                  input ready);
  modport sink (input valid, mode, capture_time, button_cw_n, button_ccw_n,
                output ready);
endinterface

interface pda_out_if;
  logic                         valid;
  logic                         ready;
  logic                         trigger_pulse;
  logic                         lamp_ready;
  logic                         lamp_warn;
  logic                         lamp_danger;
  logic                         drive_cw;
  logic                         drive_ccw;
  logic [pda_pkg::VolumeW-1:0]  buzzer_level;
  logic [pda_pkg::DistW-1:0]    distance_now;

  modport source (output valid, trigger_pulse, lamp_ready, lamp_warn, lamp_danger,
                  drive_cw, drive_ccw, buzzer_level, distance_now, input ready);
  modport sink (input valid, trigger_pulse, lamp_ready, lamp_warn, lamp_danger,
                drive_cw, drive_ccw, buzzer_level, distance_now, output ready);
endinterface

interface pda_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pda_pkg::RegIdxW-1:0]   reg_idx;
  logic [pda_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

// ----- hw/rtl/pda_core.sv -----
// ----------------------------------------------------------------------------
// pda_core: register file, alarm state and per-word datapath
// Computes the result of the staged word and commits state when it moves on.
// ----------------------------------------------------------------------------
module pda_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pda_pkg::cfg_wr_t  cfg_wr_i,
  input  logic              commit_i,
  input  pda_pkg::item_t    item_i,
  output pda_pkg::result_t  result_o
);

  // configuration registers
  logic [pda_pkg::PeriodW-1:0] trigger_period_q;
  logic [pda_pkg::LimitW-1:0]  near_limit_q, warn_limit_q;
  logic [pda_pkg::LimitW-1:0]  far_interval_q, mid_interval_q, near_interval_q;
  logic [pda_pkg::VolumeW-1:0] tone_volume_q;

  // alarm state
  logic [pda_pkg::PeriodW-1:0]  tick_count_q, tick_count_d;
  logic                         edge_phase_q, edge_phase_d;
  logic [pda_pkg::CaptureW-1:0] rise_time_q, rise_time_d;
  logic [pda_pkg::DistW-1:0]    distance_q, distance_d;
  logic [pda_pkg::LimitW-1:0]   buzzer_count_q, buzzer_count_d;
  logic [pda_pkg::VolumeW-1:0]  buzzer_duty_q, buzzer_duty_d;
  logic [3:0]                   lamp_drive_q, lamp_drive_d;

  logic [pda_pkg::CaptureW-1:0] echo_width;
  logic [pda_pkg::QuotInW-1:0]  quot_in;
  logic [pda_pkg::ProdW-1:0]    quot_prod;
  logic [pda_pkg::DistW-1:0]    echo_dist;
  logic [pda_pkg::PeriodW-1:0]  tick_inc;
  logic [pda_pkg::LimitW:0]     buzz_next;
  logic [pda_pkg::LimitW-1:0]   interval;
  logic                         cw_down, ccw_down;
  logic                         trig;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_period_q <= pda_pkg::TriggerPeriodRst;
      near_limit_q     <= pda_pkg::NearLimitRst;
      warn_limit_q     <= pda_pkg::WarnLimitRst;
      far_interval_q   <= pda_pkg::FarIntervalRst;
      mid_interval_q   <= pda_pkg::MidIntervalRst;
      near_interval_q  <= pda_pkg::NearIntervalRst;
      tone_volume_q    <= pda_pkg::ToneVolumeRst;
    end else if (cfg_wr_i.en) begin
      unique case (cfg_wr_i.idx)
        pda_pkg::REG_TRIGGER_PERIOD: trigger_period_q <= cfg_wr_i.data[pda_pkg::PeriodW-1:0];
        pda_pkg::REG_NEAR_LIMIT:     near_limit_q     <= cfg_wr_i.data;
        pda_pkg::REG_WARN_LIMIT:     warn_limit_q     <= cfg_wr_i.data;
        pda_pkg::REG_FAR_INTERVAL:   far_interval_q   <= cfg_wr_i.data;
        pda_pkg::REG_MID_INTERVAL:   mid_interval_q   <= cfg_wr_i.data;
        pda_pkg::REG_NEAR_INTERVAL:  near_interval_q  <= cfg_wr_i.data;
        pda_pkg::REG_TONE_VOLUME:    tone_volume_q    <= cfg_wr_i.data[pda_pkg::VolumeW-1:0];
        default: ;
      endcase
    end
  end

  // echo width to centimetres by reciprocal multiply
  assign echo_width = item_i.capture_time - rise_time_q;
  assign quot_in    = echo_width[pda_pkg::CaptureW-1:pda_pkg::EchoPreShift];
  assign quot_prod  = pda_pkg::ProdW'(quot_in) * pda_pkg::ProdW'(pda_pkg::RecipMul);
  assign echo_dist  = quot_prod[pda_pkg::RecipShift +: pda_pkg::DistW];

  assign cw_down     = !item_i.button_cw_n;
  assign ccw_down    = !item_i.button_ccw_n;
  assign tick_inc    = tick_count_q + 8'd1;
  assign buzz_next   = {1'b0, buzzer_count_q} + 11'd1;

  // buzzer interval by distance zone
  always_comb begin
    priority if (distance_q > warn_limit_q) begin
      interval = far_interval_q;
    end else if (distance_q >= near_limit_q) begin
      interval = mid_interval_q;
    end else begin
      interval = near_interval_q;
    end
  end

  // next state
  always_comb begin
    tick_count_d   = tick_count_q;
    edge_phase_d   = edge_phase_q;
    rise_time_d    = rise_time_q;
    distance_d     = distance_q;
    buzzer_count_d = buzzer_count_q;
    buzzer_duty_d  = buzzer_duty_q;
    lamp_drive_d   = lamp_drive_q;
    trig           = 1'b0;
    if (item_i.mode == pda_pkg::ModeEcho) begin
      if (!edge_phase_q) begin
        rise_time_d  = item_i.capture_time;
        edge_phase_d = 1'b1;
      end else begin
        distance_d   = echo_dist;
        edge_phase_d = 1'b0;
      end
    end else begin
      // trigger request
      if (tick_inc >= trigger_period_q) begin
        trig         = 1'b1;
        tick_count_d = '0;
      end else begin
        tick_count_d = tick_inc;
      end
      // lamps and motor drive
      lamp_drive_d = '0;
      if (distance_q != '0) begin
        lamp_drive_d[0] = distance_q < warn_limit_q;
        lamp_drive_d[1] = distance_q < near_limit_q;
      end
      if (distance_q > near_limit_q) begin
        lamp_drive_d[2] = cw_down && !ccw_down;
        lamp_drive_d[3] = ccw_down && !cw_down;
      end
      // buzzer toggling
      if (distance_q == '0) begin
        buzzer_duty_d  = '0;
        buzzer_count_d = '0;
      end else if (buzz_next >= {1'b0, interval}) begin
        buzzer_count_d = '0;
        buzzer_duty_d  = (buzzer_duty_q != '0) ? '0 : tone_volume_q;
      end else begin
        buzzer_count_d = buzz_next[pda_pkg::LimitW-1:0];
      end
    end
  end

  // state commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q   <= '0;
      edge_phase_q   <= 1'b0;
      rise_time_q    <= '0;
      distance_q     <= '0;
      buzzer_count_q <= '0;
      buzzer_duty_q  <= '0;
      lamp_drive_q   <= '0;
    end else if (commit_i) begin
      tick_count_q   <= tick_count_d;
      edge_phase_q   <= edge_phase_d;
      rise_time_q    <= rise_time_d;
      distance_q     <= distance_d;
      buzzer_count_q <= buzzer_count_d;
      buzzer_duty_q  <= buzzer_duty_d;
      lamp_drive_q   <= lamp_drive_d;
    end
  end

  // result word
  always_comb begin
    result_o.trigger_pulse = trig;
    result_o.lamp_ready    = 1'b1;
    result_o.lamp_warn     = lamp_drive_d[0];
    result_o.lamp_danger   = lamp_drive_d[1];
    result_o.drive_cw      = lamp_drive_d[2];
    result_o.drive_ccw     = lamp_drive_d[3];
    result_o.buzzer_level  = buzzer_duty_d;
    result_o.distance_now  = distance_d;
  end

endmodule

// ----- hw/rtl/parking_distance_alarm.sv -----
// ----------------------------------------------------------------------------
// parking_distance_alarm: ultrasonic parking distance alarm
// Echo timing to distance, trigger pacing, lamps, motor drive and buzzer.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one word per handshake: a millisecond tick (mode 0) with the
//   two active-low button levels, or an echo edge (mode 1) with its 16-bit
//   capture time. Echo edges alternate rising then falling.
//   out_o gives exactly one result word for every input word, in order.
//   cfg_i writes register reg_idx with wdata; it is always ready and should
//   be used only while no word is in flight. Unknown indexes are dropped.
//   A word accepted on in_i sits in the input stage, and its result is
//   loaded into the output register when that register is free or being
//   taken, which raises out_o.valid. Throughput: one word per cycle while
//   the receiver takes results; the state update sits between input stage
//   and output register.
//   A stalled receiver holds the result; the input stage still fills, and
//   in_i.ready drops only when both stages are full.
//   Reset clears all state, loads register defaults and empties both stages.
// ----------------------------------------------------------------------------
module parking_distance_alarm (
  input  logic       clk_i,
  input  logic       rst_ni,
  pda_in_if.sink     in_i,
  pda_out_if.source  out_o,
  pda_cfg_if.sink    cfg_i
);

  logic              stage_valid_q, stage_valid_d;
  pda_pkg::item_t    stage_item_q;
  logic              out_valid_q, out_valid_d;
  pda_pkg::result_t  out_word_q;
  pda_pkg::result_t  core_result;
  pda_pkg::cfg_wr_t  cfg_wr;
  logic              advance;
  logic              in_accept;

  // handshake control
  assign advance   = stage_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !stage_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cfg_wr.en   = cfg_i.valid;
  assign cfg_wr.idx  = cfg_i.reg_idx;
  assign cfg_wr.data = cfg_i.wdata;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_accept) begin
      stage_valid_d = 1'b1;
    end else if (advance) begin
      stage_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_item_q.mode         <= in_i.mode;
      stage_item_q.capture_time <= in_i.capture_time;
      stage_item_q.button_cw_n  <= in_i.button_cw_n;
      stage_item_q.button_ccw_n <= in_i.button_ccw_n;
    end
  end

  pda_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .commit_i (advance),
    .item_i   (stage_item_q),
    .result_o (core_result)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= core_result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.trigger_pulse = out_word_q.trigger_pulse;
  assign out_o.lamp_ready    = out_word_q.lamp_ready;
  assign out_o.lamp_warn     = out_word_q.lamp_warn;
  assign out_o.lamp_danger   = out_word_q.lamp_danger;
  assign out_o.drive_cw      = out_word_q.drive_cw;
  assign out_o.drive_ccw     = out_word_q.drive_ccw;
  assign out_o.buzzer_level  = out_word_q.buzzer_level;
  assign out_o.distance_now  = out_word_q.distance_now;

  // checks
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> stage_valid_q)
    else $error("accepted word did not reach the input stage");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input blocked while output register is empty");

  a_advance_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("staged word was lost on its way to the output");

  a_one_drive_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.drive_cw && out_word_q.drive_ccw))
    else $error("motor driven both ways");

  a_ready_lamp_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_word_q.lamp_ready)
    else $error("ready lamp dark on a valid word");

endmodule

// ----- sim/parking_distance_alarm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parking_distance_alarm_tb: self-checking bench of the parking distance alarm
// A queue-fed driver offers tick and echo words on the input channel. A
// per-word alarm predictor works out each expected result word, and the
// receiver checks every result field by field. The bench programs the registers
// between runs of words and sweeps several settings, the extremes among them.
// ----------------------------------------------------------------------------
module parking_distance_alarm_tb;
  import pda_pkg::*;

  localparam int unsigned EchoDivisor = 116;
  localparam int unsigned MaxDistCm   = 564;
  localparam int unsigned IdlePct     = 26;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned StallLimit  = 3000;
  localparam logic [RegIdxW-1:0] RegSpare = 3'd7;

  logic clk_i;
  logic rst_ni;

  pda_in_if  in_if ();
  pda_out_if out_if ();
  pda_cfg_if cfg_if ();

  parking_distance_alarm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // words waiting to be offered and results waiting to be seen
  item_t   word_backlog[$];
  result_t expected_results[$];
  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned still_cycles  = 0;
  int unsigned hold_reqs     = 0;
  int unsigned holds_taken   = 0;
  int unsigned hold_left     = 0;
  bit          quiet         = 1'b0;

  // stimulus side bookkeeping
  bit edge_open = 1'b0;
  int aim_near  = 10;
  int aim_warn  = 20;

  // alarm predictor: registers
  logic [PeriodW-1:0] trig_period;
  logic [LimitW-1:0]  near_lim;
  logic [LimitW-1:0]  warn_lim;
  logic [LimitW-1:0]  far_iv;
  logic [LimitW-1:0]  mid_iv;
  logic [LimitW-1:0]  near_iv;
  logic [VolumeW-1:0] tone_vol;

  // alarm predictor: state
  logic [PeriodW-1:0]  tick_cnt;
  logic                awaiting_fall;
  logic [CaptureW-1:0] rise_cap;
  logic [DistW-1:0]    dist_cm;
  logic [LimitW-1:0]   buzz_cnt;
  logic [VolumeW-1:0]  buzz_duty;
  logic                warn_lit;
  logic                danger_lit;
  logic                cw_on;
  logic                ccw_on;

  function automatic void alarm_reset();
    trig_period   = TriggerPeriodRst;
    near_lim      = NearLimitRst;
    warn_lim      = WarnLimitRst;
    far_iv        = FarIntervalRst;
    mid_iv        = MidIntervalRst;
    near_iv       = NearIntervalRst;
    tone_vol      = ToneVolumeRst;
    tick_cnt      = '0;
    awaiting_fall = 1'b0;
    rise_cap      = '0;
    dist_cm       = '0;
    buzz_cnt      = '0;
    buzz_duty     = '0;
    warn_lit      = 1'b0;
    danger_lit    = 1'b0;
    cw_on         = 1'b0;
    ccw_on        = 1'b0;
  endfunction

  function automatic void track_register(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (cfg_reg_e'(idx))
      REG_TRIGGER_PERIOD: trig_period = val[PeriodW-1:0];
      REG_NEAR_LIMIT:     near_lim    = val;
      REG_WARN_LIMIT:     warn_lim    = val;
      REG_FAR_INTERVAL:   far_iv      = val;
      REG_MID_INTERVAL:   mid_iv      = val;
      REG_NEAR_INTERVAL:  near_iv     = val;
      REG_TONE_VOLUME:    tone_vol    = val[VolumeW-1:0];
      default: ;
    endcase
  endfunction

  // state update for one word and the result word it yields
  function automatic result_t alarm_next_result(item_t w);
    result_t             r;
    logic [CaptureW-1:0] width;
    logic [LimitW-1:0]   ivl;
    int unsigned         nxt;
    r = '0;
    if (w.mode == ModeEcho) begin
      if (!awaiting_fall) begin
        rise_cap      = w.capture_time;
        awaiting_fall = 1'b1;
      end else begin
        width         = w.capture_time - rise_cap;
        dist_cm       = DistW'(width / EchoDivisor);
        awaiting_fall = 1'b0;
      end
    end else begin
      // trigger pacing
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= trig_period) begin
        r.trigger_pulse = 1'b1;
        tick_cnt        = '0;
      end
      // lamps, dark with no distance
      warn_lit   = (dist_cm != 0) && (dist_cm < warn_lim);
      danger_lit = (dist_cm != 0) && (dist_cm < near_lim);
      // motor runs only clear of the danger zone with exactly one button down
      cw_on  = (dist_cm > near_lim) && !w.button_cw_n && w.button_ccw_n;
      ccw_on = (dist_cm > near_lim) && !w.button_ccw_n && w.button_cw_n;
      // buzzer toggling by zone
      if (dist_cm == 0) begin
        buzz_duty = '0;
        buzz_cnt  = '0;
      end else begin
        if (dist_cm > warn_lim) ivl = far_iv;
        else if (dist_cm >= near_lim) ivl = mid_iv;
        else ivl = near_iv;
        nxt = buzz_cnt + 1;
        if (nxt >= ivl) begin
          buzz_cnt  = '0;
          buzz_duty = (buzz_duty != 0) ? '0 : tone_vol;
        end else begin
          buzz_cnt = LimitW'(nxt);
        end
      end
    end
    r.lamp_ready   = 1'b1;
    r.lamp_warn    = warn_lit;
    r.lamp_danger  = danger_lit;
    r.drive_cw     = cw_on;
    r.drive_ccw    = ccw_on;
    r.buzzer_level = buzz_duty;
    r.distance_now = dist_cm;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_word(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      note_mismatch($sformatf("result word with nothing expected: %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.trigger_pulse !== want.trigger_pulse)
      note_mismatch($sformatf("trigger_pulse %b, want %b", got.trigger_pulse, want.trigger_pulse));
    if (got.lamp_ready !== want.lamp_ready)
      note_mismatch($sformatf("lamp_ready %b, want %b", got.lamp_ready, want.lamp_ready));
    if (got.lamp_warn !== want.lamp_warn)
      note_mismatch($sformatf("lamp_warn %b, want %b", got.lamp_warn, want.lamp_warn));
    if (got.lamp_danger !== want.lamp_danger)
      note_mismatch($sformatf("lamp_danger %b, want %b", got.lamp_danger, want.lamp_danger));
    if (got.drive_cw !== want.drive_cw)
      note_mismatch($sformatf("drive_cw %b, want %b", got.drive_cw, want.drive_cw));
    if (got.drive_ccw !== want.drive_ccw)
      note_mismatch($sformatf("drive_ccw %b, want %b", got.drive_ccw, want.drive_ccw));
    if (got.buzzer_level !== want.buzzer_level)
      note_mismatch($sformatf("buzzer_level %0d, want %0d", got.buzzer_level,
                              want.buzzer_level));
    if (got.distance_now !== want.distance_now)
      note_mismatch($sformatf("distance_now %0d, want %0d", got.distance_now,
                              want.distance_now));
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // reset, held low at start and then released
  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: offers backlog words, predicts accepted ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.mode         <= ModeTick;
      in_if.capture_time <= '0;
      in_if.button_cw_n  <= 1'b1;
      in_if.button_ccw_n <= 1'b1;
      alarm_reset();
    end else begin
      if (cfg_if.valid && cfg_if.ready) track_register(cfg_if.reg_idx, cfg_if.wdata);
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(alarm_next_result('{mode: in_if.mode,
          capture_time: in_if.capture_time, button_cw_n: in_if.button_cw_n,
          button_ccw_n: in_if.button_ccw_n}));
        words_taken++;
      end
      // a held word stays until taken
      if (!in_if.valid || in_if.ready) begin
        if (word_backlog.size() > 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
          item_t w;
          w = word_backlog.pop_front();
          in_if.valid        <= 1'b1;
          in_if.mode         <= w.mode;
          in_if.capture_time <= w.capture_time;
          in_if.button_cw_n  <= w.button_cw_n;
          in_if.button_ccw_n <= w.button_ccw_n;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks result words, random stalls and long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_word('{trigger_pulse: out_if.trigger_pulse, lamp_ready: out_if.lamp_ready,
          lamp_warn: out_if.lamp_warn, lamp_danger: out_if.lamp_danger,
          drive_cw: out_if.drive_cw, drive_ccw: out_if.drive_ccw,
          buzzer_level: out_if.buzzer_level, distance_now: out_if.distance_now});
        results_seen++;
      end
      if (hold_reqs != holds_taken) begin
        holds_taken++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        still_cycles = 0;
      end else begin
        still_cycles++;
        if (still_cycles >= StallLimit) begin
          $display("FAIL parking_distance_alarm");
          $finish;
        end
      end
    end
  end

  // stimulus helpers
  task automatic queue_word(item_t w);
    word_backlog.push_back(w);
    words_queued++;
  endtask

  task automatic queue_tick(logic cw_n, logic ccw_n);
    item_t w;
    w.mode         = ModeTick;
    w.capture_time = CaptureW'($urandom);
    w.button_cw_n  = cw_n;
    w.button_ccw_n = ccw_n;
    queue_word(w);
  endtask

  task automatic queue_echo(logic [CaptureW-1:0] t);
    item_t w;
    w.mode         = ModeEcho;
    w.capture_time = t;
    w.button_cw_n  = 1'($urandom);
    w.button_ccw_n = 1'($urandom);
    queue_word(w);
    edge_open = !edge_open;
  endtask

  // rising and falling edge at a zone boundary, near zero, at the maximum or random; closes a stray edge first
  task automatic queue_echo_pair();
    logic [CaptureW-1:0] rise;
    int                  cm;
    int                  span;
    if (edge_open) queue_echo(CaptureW'($urandom));
    case ($urandom_range(0, 5))
      0: cm = $urandom_range(0, 2);
      1: cm = aim_near - 1 + $urandom_range(0, 2);
      2: cm = aim_warn - 1 + $urandom_range(0, 2);
      3: cm = $urandom_range(0, MaxDistCm);
      4: cm = MaxDistCm;
      default: cm = $urandom_range(3, 40);
    endcase
    if (cm < 0) cm = 0;
    if (cm > MaxDistCm) cm = MaxDistCm;
    span = cm * EchoDivisor + $urandom_range(0, EchoDivisor - 1);
    if (span > 65535) span = 65535;
    rise = CaptureW'($urandom);
    queue_echo(rise);
    queue_echo(rise + CaptureW'(span));
  endtask

  task automatic queue_burst(int n);
    int left;
    int pick;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_echo_pair();
        left -= 2;
      end else if (pick < 13) begin
        queue_echo(CaptureW'($urandom));
        left--;
      end else begin
        queue_tick(1'($urandom), 1'($urandom));
        left--;
      end
    end
  endtask

  task automatic cfg_put(logic [RegIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= val;
    cfg_if.valid   <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // full register set, plus a write to the unused index
  task automatic program_alarm(int period, int near, int warn, int far, int mid,
                               int nearv, int vol);
    cfg_put(RegSpare, CfgDataW'($urandom));
    cfg_put(REG_TRIGGER_PERIOD, CfgDataW'(period));
    cfg_put(REG_NEAR_LIMIT, CfgDataW'(near));
    cfg_put(REG_WARN_LIMIT, CfgDataW'(warn));
    cfg_put(REG_FAR_INTERVAL, CfgDataW'(far));
    cfg_put(REG_MID_INTERVAL, CfgDataW'(mid));
    cfg_put(REG_NEAR_INTERVAL, CfgDataW'(nearv));
    cfg_put(REG_TONE_VOLUME, CfgDataW'(vol));
    cfg_if.valid <= 1'b0;
    aim_near = near;
    aim_warn = warn;
  endtask

  // every word answered, then a margin before returning
  task automatic wait_idle();
    while (!(words_taken == words_queued && expected_results.size() == 0))
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // sequence of runs
  initial begin
    int near;
    cfg_if.valid   <= 1'b0;
    cfg_if.reg_idx <= REG_TRIGGER_PERIOD;
    cfg_if.wdata   <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed words under reset settings
    queue_tick(1'b1, 1'b1);
    queue_tick(1'b0, 1'b1);
    queue_echo(16'h0000);
    queue_echo(16'hFFFF);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b1, 1'b1);
    // wrapped echo width yields no distance
    queue_echo(16'hFFFF);
    queue_echo(16'h0000);
    queue_tick(1'b0, 1'b1);
    // danger zone, then exactly at the near limit, just above it
    queue_echo(16'd1000);
    queue_echo(16'd1000 + 16'(5 * EchoDivisor));
    queue_tick(1'b0, 1'b1);
    queue_echo(16'd2000);
    queue_echo(16'd2000 + 16'(10 * EchoDivisor + EchoDivisor - 1));
    queue_tick(1'b0, 1'b1);
    queue_echo(16'd3000);
    queue_echo(16'd3000 + 16'(11 * EchoDivisor));
    queue_tick(1'b1, 1'b0);
    // exactly at the warn limit, then just beyond
    queue_echo(16'd4000);
    queue_echo(16'd4000 + 16'(20 * EchoDivisor));
    queue_tick(1'b0, 1'b1);
    queue_echo(16'd5000);
    queue_echo(16'd5000 + 16'(21 * EchoDivisor));
    queue_tick(1'b1, 1'b0);
    wait_idle();

    queue_burst(150);
    wait_idle();

    // short intervals, no idling on either side
    program_alarm(3, 10, 20, 6, 4, 2, 80);
    quiet = 1'b1;
    queue_burst(220);
    wait_idle();
    quiet = 1'b0;

    // all registers at zero
    program_alarm(0, 0, 0, 0, 0, 0, 0);
    queue_burst(150);
    wait_idle();

    // limits at the top, intervals of one, long receiver hold-off
    program_alarm(1, 1023, 1023, 1, 1, 1, 255);
    hold_reqs++;
    queue_burst(150);
    wait_idle();

    // upper data bits on the 8-bit registers are dropped
    program_alarm(10'h3FF, 300, 500, 1023, 7, 3, 10'h301);
    queue_burst(150);
    wait_idle();

    // random settings with short intervals
    for (int p = 0; p < 5; p++) begin
      near = $urandom_range(0, 60);
      program_alarm(($urandom_range(0, 3) << 8) | $urandom_range(0, 12), near,
                    near + $urandom_range(0, 60), $urandom_range(0, 9),
                    $urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 1023));
      if (p == 2) hold_reqs++;
      queue_burst(180);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS parking_distance_alarm");
    end else begin
      $display("FAIL parking_distance_alarm");
    end
    $finish;
  end

endmodule
